FILE: rtl/core/fss_pkg.sv
package fss_pkg;

   // Field widths of the request and response items.
   localparam int COORD_W    = 16;
   localparam int QUAL_W     = 16;
   localparam int SUM_W      = 32;
   localparam int CFG_W      = 12;
   localparam int THR_W      = 2 * CFG_W;
   localparam int OUT_IDX_W  = 6;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int SQ_W       = PROD_W + 1;
   localparam int EXT_W      = SQ_W + 1;
   localparam int REQ_DATA_W = 3 * COORD_W;
   localparam int RSP_DATA_W = 8;

   localparam logic [CFG_W-1:0] MIN_DIST_RESET = 12'd10;
   localparam logic [SUM_W-1:0] SUM_MAX        = {SUM_W{1'b1}};

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_ACCUM,
      ST_UPDATE,
      ST_FINISH,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   // Control of the shared squaring unit.
   typedef struct packed {
      logic sel_y;
      logic load;
      logic accum;
   } dist_ctl_type;

   // Control of the selection scan.
   typedef struct packed {
      logic clear;
      logic step;
   } sel_ctl_type;

   // Adds a distance to a distance sum, saturating at the all-ones value.
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SQ_W-1:0]  d);
      logic [EXT_W-1:0] t;
      t = EXT_W'(s) + EXT_W'(d);
      return (t > EXT_W'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
   endfunction

endpackage

FILE: rtl/core/feature_sparsify_select.sv
// Picks at most one feature point of a frame to drop for lying too close to another.
// Requests arrive on the req_ channel, one feature point each; req_tlast marks
// the final point of a frame. Each loaded point is compared with every point
// stored before it, one stored point at a time, through a single shared
// multiplier that squares the x and then the y difference. While a point is
// loaded and compared, req_tready is low: the block takes no new request until
// it is through with the one before. On a request with req_tlast set, the block
// then scans all stored points, one per cycle, and in a drain state hands the
// choice to the output register once that register is free; rsp_tvalid rises
// the cycle after the hand-over. Exactly one response is given per frame.
// Points beyond MAX_POINTS are not stored or compared. The threshold is written
// through csr_wr_en and csr_wr_data; the user must write it only while idle,
// as the block itself does not enforce this.
// A held response stays in the output register while rsp_tready is low, and
// further requests are still taken; a second frame end then waits until the
// register is free. Reset empties the store and sets the threshold to 10 pixels.
module feature_sparsify_select #(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: pos_x [15:0], pos_y [31:16], quality [47:32].
   input  logic [fss_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: drop_index [5:0], zero [7:6].
   output logic [fss_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: drop_found [0].
   output logic                              rsp_tuser,
   // Threshold register.
   input  logic                              csr_wr_en,
   input  logic [fss_pkg::CFG_W-1:0]         csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   fss_pkg::state_type state_ff;
   fss_pkg::state_type state_in;

   logic [CNT_W-1:0]                cnt_ff;
   logic [CNT_W-1:0]                cnt_in;
   logic [IDX_W-1:0]                idx_ff;
   logic [IDX_W-1:0]                idx_in;
   logic                            last_ff;
   logic [fss_pkg::COORD_W-1:0]     px_ff;
   logic [fss_pkg::COORD_W-1:0]     py_ff;
   logic [fss_pkg::SUM_W-1:0]       nsum_ff;
   logic [fss_pkg::SUM_W-1:0]       nsum_in;
   logic [fss_pkg::THR_W-1:0]       thr_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_found_ff;
   logic [fss_pkg::OUT_IDX_W-1:0]   rsp_index_ff;
   logic                            rsp_load;

   logic                            req_accept;
   logic                            store_full;
   logic                            idx_is_last;
   logic [fss_pkg::COORD_W-1:0]     req_x;
   logic [fss_pkg::COORD_W-1:0]     req_y;
   logic [fss_pkg::QUAL_W-1:0]      req_q;

   logic                            pt_we;
   logic                            sum_we;
   logic [IDX_W-1:0]                sum_addr;
   logic [fss_pkg::SUM_W-1:0]       sum_wdata;
   logic                            flag_we;
   logic [IDX_W-1:0]                flag_addr;
   logic                            flag_wdata;
   logic [fss_pkg::COORD_W-1:0]     rd_x;
   logic [fss_pkg::COORD_W-1:0]     rd_y;
   logic [fss_pkg::QUAL_W-1:0]      rd_q;
   logic [fss_pkg::SUM_W-1:0]       rd_sum;
   logic                            rd_flag;
   logic [fss_pkg::SQ_W-1:0]        sq_dist;
   logic                            dist_close;
   logic                            sel_found;
   logic [IDX_W-1:0]                sel_idx;

   fss_pkg::dist_ctl_type           dist_ctl;
   fss_pkg::sel_ctl_type            sel_ctl;

   assign req_x       = req_tdata[fss_pkg::COORD_W-1:0];
   assign req_y       = req_tdata[2*fss_pkg::COORD_W-1:fss_pkg::COORD_W];
   assign req_q       = req_tdata[3*fss_pkg::COORD_W-1:2*fss_pkg::COORD_W];
   assign req_tready  = (state_ff == fss_pkg::ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign store_full  = (cnt_ff == CNT_W'(MAX_POINTS));
   assign idx_is_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign dist_close  = (sq_dist <= fss_pkg::SQ_W'(thr_ff));

   // Sequencer: compare loop, then the selection scan on a frame end.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      nsum_in      = nsum_ff;
      pt_we        = 1'b0;
      sum_we       = 1'b0;
      sum_addr     = idx_ff;
      sum_wdata    = fss_pkg::sat_add(rd_sum, sq_dist);
      flag_we      = 1'b0;
      flag_addr    = idx_ff;
      flag_wdata   = rd_flag || dist_close;
      dist_ctl     = '0;
      sel_ctl      = '0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         fss_pkg::ST_IDLE: begin
            if (req_accept) begin
               idx_in = '0;
               if (!store_full) begin
                  pt_we      = 1'b1;
                  flag_we    = 1'b1;
                  flag_addr  = cnt_ff[IDX_W-1:0];
                  flag_wdata = 1'b0;
                  nsum_in    = '0;
                  state_in   = (cnt_ff == '0) ? fss_pkg::ST_FINISH : fss_pkg::ST_MUL_X;
               end else if (req_tlast) begin
                  sel_ctl.clear = 1'b1;
                  state_in      = fss_pkg::ST_SCAN;
               end
            end
         end
         fss_pkg::ST_MUL_X: begin
            state_in = fss_pkg::ST_MUL_Y;
         end
         fss_pkg::ST_MUL_Y: begin
            dist_ctl.sel_y = 1'b1;
            dist_ctl.load  = 1'b1;
            state_in       = fss_pkg::ST_ACCUM;
         end
         fss_pkg::ST_ACCUM: begin
            dist_ctl.accum = 1'b1;
            state_in       = fss_pkg::ST_UPDATE;
         end
         fss_pkg::ST_UPDATE: begin
            // Both points' sums take the distance; the earlier point may join.
            sum_we  = 1'b1;
            flag_we = 1'b1;
            nsum_in = fss_pkg::sat_add(nsum_ff, sq_dist);
            if (idx_is_last) begin
               state_in = fss_pkg::ST_FINISH;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = fss_pkg::ST_MUL_X;
            end
         end
         fss_pkg::ST_FINISH: begin
            sum_we    = 1'b1;
            sum_addr  = cnt_ff[IDX_W-1:0];
            sum_wdata = nsum_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            idx_in    = '0;
            if (last_ff) begin
               sel_ctl.clear = 1'b1;
               state_in      = fss_pkg::ST_SCAN;
            end else begin
               state_in = fss_pkg::ST_IDLE;
            end
         end
         fss_pkg::ST_SCAN: begin
            sel_ctl.step = 1'b1;
            if (idx_is_last) begin
               state_in = fss_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         fss_pkg::ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               cnt_in   = '0;
               state_in = fss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fss_pkg::ST_IDLE;
         cnt_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
      end
   end

   // Request payload and running sum of the newly loaded point.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         px_ff   <= req_x;
         py_ff   <= req_y;
         last_ff <= req_tlast;
      end
      nsum_ff <= nsum_in;
   end

   // Squared threshold, kept ready for the compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= fss_pkg::THR_W'(fss_pkg::MIN_DIST_RESET) *
                   fss_pkg::THR_W'(fss_pkg::MIN_DIST_RESET);
      end else if (csr_wr_en) begin
         thr_ff <= fss_pkg::THR_W'(csr_wr_data) * fss_pkg::THR_W'(csr_wr_data);
      end
   end

   // Output register; holds the response until the receiver takes it.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff <= sel_found;
         rsp_index_ff <= sel_found ? fss_pkg::OUT_IDX_W'(sel_idx) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(fss_pkg::RSP_DATA_W - fss_pkg::OUT_IDX_W){1'b0}}, rsp_index_ff};

   // The read address follows the next loop index, so registered data matches idx_ff.
   fss_store #(
      .DEPTH (MAX_POINTS),
      .AW    (IDX_W)
   ) u_store (
      .clock      (clock),
      .pt_we      (pt_we),
      .pt_addr    (cnt_ff[IDX_W-1:0]),
      .pt_x       (req_x),
      .pt_y       (req_y),
      .pt_q       (req_q),
      .sum_we     (sum_we),
      .sum_addr   (sum_addr),
      .sum_wdata  (sum_wdata),
      .flag_we    (flag_we),
      .flag_addr  (flag_addr),
      .flag_wdata (flag_wdata),
      .rd_addr    (idx_in),
      .rd_x       (rd_x),
      .rd_y       (rd_y),
      .rd_q       (rd_q),
      .rd_sum     (rd_sum),
      .rd_flag    (rd_flag)
   );

   fss_dist_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dist (
      .clock   (clock),
      .ctl     (dist_ctl),
      .mem_x   (rd_x),
      .mem_y   (rd_y),
      .pt_x    (px_ff),
      .pt_y    (py_ff),
      .sq_dist (sq_dist)
   );

   fss_select #(
      .IDX_W (IDX_W)
   ) u_select (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sel_ctl),
      .idx      (idx_ff),
      .rd_q     (rd_q),
      .rd_sum   (rd_sum),
      .rd_flag  (rd_flag),
      .found    (sel_found),
      .best_idx (sel_idx)
   );

   // The fill count never passes the store depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond store depth");

   // Loop and scan indices only visit loaded entries.
   a_idx_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fss_pkg::ST_UPDATE || state_ff == fss_pkg::ST_SCAN) |->
      (CNT_W'(idx_ff) < cnt_ff))
      else $error("index outside loaded entries");

   // A request into a non-empty, non-full store starts the compare loop at entry zero.
   a_loop_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !store_full && cnt_ff != '0) |=>
      (state_ff == fss_pkg::ST_MUL_X && idx_ff == '0))
      else $error("compare loop did not start");

   // Handing over the choice empties the frame and raises the response.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fss_pkg::ST_DRAIN && (!rsp_valid_ff || rsp_tready)) |=>
      (rsp_tvalid && cnt_ff == '0 && state_ff == fss_pkg::ST_IDLE))
      else $error("frame end not handed over");

endmodule

FILE: rtl/core/fss_store.sv
module fss_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          pt_we,
   input  logic [AW-1:0]                 pt_addr,
   input  logic [fss_pkg::COORD_W-1:0]   pt_x,
   input  logic [fss_pkg::COORD_W-1:0]   pt_y,
   input  logic [fss_pkg::QUAL_W-1:0]    pt_q,
   input  logic                          sum_we,
   input  logic [AW-1:0]                 sum_addr,
   input  logic [fss_pkg::SUM_W-1:0]     sum_wdata,
   input  logic                          flag_we,
   input  logic [AW-1:0]                 flag_addr,
   input  logic                          flag_wdata,
   input  logic [AW-1:0]                 rd_addr,
   output logic [fss_pkg::COORD_W-1:0]   rd_x,
   output logic [fss_pkg::COORD_W-1:0]   rd_y,
   output logic [fss_pkg::QUAL_W-1:0]    rd_q,
   output logic [fss_pkg::SUM_W-1:0]     rd_sum,
   output logic                          rd_flag
);

   logic [fss_pkg::COORD_W-1:0] x_mem    [DEPTH];
   logic [fss_pkg::COORD_W-1:0] y_mem    [DEPTH];
   logic [fss_pkg::QUAL_W-1:0]  q_mem    [DEPTH];
   logic [fss_pkg::SUM_W-1:0]   sum_mem  [DEPTH];
   logic                        flag_mem [DEPTH];

   // Point data is written once, when the point is loaded.
   always_ff @(posedge clock) begin
      if (pt_we) begin
         x_mem[pt_addr] <= pt_x;
         y_mem[pt_addr] <= pt_y;
         q_mem[pt_addr] <= pt_q;
      end
      rd_x <= x_mem[rd_addr];
      rd_y <= y_mem[rd_addr];
      rd_q <= q_mem[rd_addr];
   end

   // Distance sums are updated by read-modify-write during the compare loop.
   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_addr] <= sum_wdata;
      end
      rd_sum <= sum_mem[rd_addr];
   end

   // Contest marks are cleared on load and set during the compare loop.
   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[flag_addr] <= flag_wdata;
      end
      rd_flag <= flag_mem[rd_addr];
   end

endmodule

FILE: rtl/core/fss_dist_unit.sv
module fss_dist_unit #(
   parameter int FRAC_BITS = 4
) (
   input  logic                          clock,
   input  fss_pkg::dist_ctl_type         ctl,
   input  logic [fss_pkg::COORD_W-1:0]   mem_x,
   input  logic [fss_pkg::COORD_W-1:0]   mem_y,
   input  logic [fss_pkg::COORD_W-1:0]   pt_x,
   input  logic [fss_pkg::COORD_W-1:0]   pt_y,
   output logic [fss_pkg::SQ_W-1:0]      sq_dist
);

   localparam int SQ_SHIFT = 2 * FRAC_BITS;
   localparam logic [fss_pkg::SQ_W-1:0] SQ_HALF = fss_pkg::SQ_W'((1 << SQ_SHIFT) >> 1);

   logic [fss_pkg::COORD_W-1:0] op_a;
   logic [fss_pkg::COORD_W-1:0] op_b;
   logic [fss_pkg::COORD_W-1:0] op_diff;
   logic [fss_pkg::PROD_W-1:0]  prod_in;
   logic [fss_pkg::PROD_W-1:0]  prod_ff;
   logic [fss_pkg::SQ_W-1:0]    acc_in;
   logic [fss_pkg::SQ_W-1:0]    acc_ff;

   // The single multiplier squares either the x or the y difference.
   always_comb begin
      op_a    = ctl.sel_y ? mem_y : mem_x;
      op_b    = ctl.sel_y ? pt_y  : pt_x;
      op_diff = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
      prod_in = fss_pkg::PROD_W'(op_diff) * fss_pkg::PROD_W'(op_diff);
   end

   // The accumulator starts with the x square plus the rounding half, then adds y.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = fss_pkg::SQ_W'(prod_ff) + SQ_HALF;
      end else if (ctl.accum) begin
         acc_in = acc_ff + fss_pkg::SQ_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Rounded squared distance in whole pixels squared.
   assign sq_dist = acc_ff >> SQ_SHIFT;

endmodule

FILE: rtl/core/fss_select.sv
module fss_select #(
   parameter int IDX_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fss_pkg::sel_ctl_type        ctl,
   input  logic [IDX_W-1:0]            idx,
   input  logic [fss_pkg::QUAL_W-1:0]  rd_q,
   input  logic [fss_pkg::SUM_W-1:0]   rd_sum,
   input  logic                        rd_flag,
   output logic                        found,
   output logic [IDX_W-1:0]            best_idx
);

   logic                       found_ff;
   logic                       found_in;
   logic [fss_pkg::QUAL_W-1:0] best_q_ff;
   logic [fss_pkg::SUM_W-1:0]  best_sum_ff;
   logic [IDX_W-1:0]           best_idx_ff;
   logic                       better;

   // A contest member wins on lower quality, then on smaller distance sum.
   // Strict compares keep the earlier entry on a full tie.
   always_comb begin
      better = rd_flag && (!found_ff || (rd_q < best_q_ff) ||
                           ((rd_q == best_q_ff) && (rd_sum < best_sum_ff)));
      found_in = found_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.step && better) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // The best candidate so far.
   always_ff @(posedge clock) begin
      if (ctl.step && better) begin
         best_q_ff   <= rd_q;
         best_sum_ff <= rd_sum;
         best_idx_ff <= idx;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;

endmodule

FILE: tb/sv/feature_sparsify_select_tb.sv
module feature_sparsify_select_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS    = 64;
   localparam int FRAC_BITS     = 4;
   localparam int HALF_PERIOD   = 10;
   localparam int DRAIN_CYCLES  = 5 * MAX_POINTS + 16;
   localparam int TARGET_POINTS = 1000;
   localparam int QUIET_FROM    = 850;
   localparam int PHASE_POINTS  = 120;
   localparam int PX            = 1 << FRAC_BITS;
   localparam int SQ_SHIFT      = 2 * FRAC_BITS;
   localparam longint unsigned ROUND_HALF = (FRAC_BITS == 0) ? 0 : (64'd1 << (SQ_SHIFT - 1));

   typedef logic [fss_pkg::COORD_W-1:0] coord_type;
   typedef logic [fss_pkg::QUAL_W-1:0]  qual_type;

   typedef struct {
      bit                            found;
      logic [fss_pkg::OUT_IDX_W-1:0] index;
   } drop_choice_type;

   // Tracks the points of the current frame and works out which one is dropped.
   class drop_chooser;
      logic [fss_pkg::CFG_W-1:0] min_dist;
      coord_type                 xs[MAX_POINTS];
      coord_type                 ys[MAX_POINTS];
      qual_type                  qs[MAX_POINTS];
      logic [fss_pkg::SUM_W-1:0] sums[MAX_POINTS];
      bit                        contest[MAX_POINTS];
      int unsigned               loaded;
      drop_choice_type           expected_drops[$];
      int unsigned               failures;

      function new();
         min_dist = fss_pkg::MIN_DIST_RESET;
         loaded   = 0;
         failures = 0;
      endfunction

      // Adds a distance to a sum, holding at the all-ones value.
      function logic [fss_pkg::SUM_W-1:0] add_capped(logic [fss_pkg::SUM_W-1:0] sum,
                                                     longint unsigned d);
         longint unsigned total;
         total = 64'(sum) + d;
         return (total > 64'(fss_pkg::SUM_MAX)) ? fss_pkg::SUM_MAX
                                                : total[fss_pkg::SUM_W-1:0];
      endfunction

      // Loads one accepted request; a frame end queues the expected choice.
      function void load_point(coord_type x, coord_type y, qual_type q, bit last);
         longint unsigned dx, dy, d, thr;
         int unsigned     i, best;
         bit              found;
         drop_choice_type choice;
         thr = 64'(min_dist) * 64'(min_dist);
         if (loaded < MAX_POINTS) begin
            xs[loaded]      = x;
            ys[loaded]      = y;
            qs[loaded]      = q;
            sums[loaded]    = '0;
            contest[loaded] = 1'b0;
            for (i = 0; i < loaded; i++) begin
               dx = (xs[i] > x) ? 64'(xs[i] - x) : 64'(x - xs[i]);
               dy = (ys[i] > y) ? 64'(ys[i] - y) : 64'(y - ys[i]);
               d  = (dx * dx + dy * dy + ROUND_HALF) >> SQ_SHIFT;
               sums[i]      = add_capped(sums[i], d);
               sums[loaded] = add_capped(sums[loaded], d);
               if (d <= thr) begin
                  contest[i] = 1'b1;
               end
            end
            loaded++;
         end
         if (last) begin
            found = 1'b0;
            best  = 0;
            // Lowest quality wins; ties go to the smaller sum, then the earlier point.
            for (i = 0; i < loaded; i++) begin
               if (contest[i] && (!found || qs[i] < qs[best] ||
                                  (qs[i] == qs[best] && sums[i] < sums[best]))) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            choice.found = found;
            choice.index = found ? fss_pkg::OUT_IDX_W'(best) : '0;
            expected_drops.insert(expected_drops.size(), choice);
            loaded = 0;
         end
      endfunction

      // Compares one accepted response with the oldest expected choice.
      function void check_drop(logic found, logic [fss_pkg::OUT_IDX_W-1:0] index);
         drop_choice_type want;
         if (expected_drops.size() == 0) begin
            $error("unexpected response: drop_found %0d, drop_index %0d", found, index);
            failures++;
         end else begin
            want = expected_drops.pop_front();
            if (found !== want.found) begin
               $error("drop_found: expected %0d, actual %0d", want.found, found);
               failures++;
            end
            if (index !== want.index) begin
               $error("drop_index: expected %0d, actual %0d", want.index, index);
               failures++;
            end
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [fss_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [fss_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_wr_en;
   logic [fss_pkg::CFG_W-1:0]        csr_wr_data;

   drop_chooser chooser = new();
   int unsigned points_sent = 0;
   bit          quiet_tail  = 1'b0;

   feature_sparsify_select #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Both channels are observed on the edge that completes each handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            chooser.load_point(req_tdata[fss_pkg::COORD_W-1:0],
                               req_tdata[2*fss_pkg::COORD_W-1:fss_pkg::COORD_W],
                               req_tdata[3*fss_pkg::COORD_W-1:2*fss_pkg::COORD_W],
                               req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            chooser.check_drop(rsp_tuser, rsp_tdata[fss_pkg::OUT_IDX_W-1:0]);
         end
      end
   end

   // The response side stalls in random bursts until the final stretch.
   initial begin
      rsp_tready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one point, sometimes after a random pause, and waits for its request to be taken.
   task automatic send_point(input coord_type x, input coord_type y, input qual_type q,
                             input bit last);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {q, y, x};
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      points_sent++;
      if (points_sent >= QUIET_FROM) begin
         quiet_tail = 1'b1;
      end
   endtask

   // Holds off new requests until every expected response is in and the block is idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (chooser.expected_drops.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [fss_pkg::CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      chooser.min_dist = value;
   endtask

   // Sends one frame; most frames are clustered around the threshold so that contests occur.
   task automatic send_frame(input int unsigned size);
      int unsigned mode, spread, base_x, base_y, k;
      bit          tie_prone;
      coord_type   x, y;
      qual_type    q;
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
         spread = (chooser.min_dist + 1) * PX * $urandom_range(1, 3);
      end else if (mode < 15) begin
         spread = $urandom_range(0, 24);
      end else begin
         spread = 65535;
      end
      if (spread > 65535) begin
         spread = 65535;
      end
      base_x    = $urandom_range(0, 65535 - spread);
      base_y    = $urandom_range(0, 65535 - spread);
      tie_prone = $urandom_range(0, 1);
      for (k = 0; k < size; k++) begin
         x = coord_type'(base_x + $urandom_range(0, spread));
         y = coord_type'(base_y + $urandom_range(0, spread));
         q = tie_prone ? qual_type'($urandom_range(0, 3)) : qual_type'($urandom());
         send_point(x, y, q, k == size - 1);
      end
   endtask

   initial begin
      int unsigned phase, phase_start, size;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Threshold left at its reset value of ten pixels.
      // A single point frame has nothing to compare with.
      send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
      // Two points one pixel apart at the top corner.
      send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_point(16'hFFEF, 16'hFFFF, 16'h0001, 1'b1);
      // Equal qualities: the smaller distance sum decides.
      send_point(16'(1000 * PX), 16'(1000 * PX), 16'd7, 1'b0);
      send_point(16'(1005 * PX), 16'(1000 * PX), 16'd7, 1'b0);
      send_point(16'(1008 * PX), 16'(1000 * PX), 16'd7, 1'b0);
      send_point(16'(3000 * PX), 16'(1000 * PX), 16'd0, 1'b1);
      // Identical points and qualities: the earliest point wins.
      send_point(16'h1234, 16'h4321, 16'd3, 1'b0);
      send_point(16'h1234, 16'h4321, 16'd3, 1'b0);
      send_point(16'h1234, 16'h4321, 16'd3, 1'b1);
      settle();

      // Zero threshold: only points that round to zero distance count.
      write_threshold(12'd0);
      send_point(16'(500 * PX), 16'(500 * PX), 16'h8000, 1'b0);
      send_point(16'(501 * PX), 16'(500 * PX), 16'h0001, 1'b0);
      send_point(16'(500 * PX), 16'(500 * PX), 16'h7FFF, 1'b1);
      // Half a pixel rounds down to zero.
      send_point(16'(500 * PX), 16'(500 * PX), 16'd9, 1'b0);
      send_point(16'(500 * PX + 8), 16'(500 * PX), 16'd4, 1'b1);
      // Three quarters of a pixel rounds up to one.
      send_point(16'(500 * PX), 16'(500 * PX), 16'd9, 1'b0);
      send_point(16'(500 * PX + 12), 16'(500 * PX), 16'd4, 1'b1);
      settle();

      // Largest threshold: a full-width step along one axis lands exactly on it.
      write_threshold(12'hFFF);
      send_point(16'h0000, 16'h0000, 16'h8000, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
      send_point(16'hFFF0, 16'h0000, 16'hFFFF, 1'b1);

      // Random phases, each under its own threshold.
      phase = 0;
      while (points_sent < TARGET_POINTS) begin
         phase++;
         settle();
         case ($urandom_range(0, 4))
            0: write_threshold(12'd0);
            1: write_threshold(12'hFFF);
            2: write_threshold(fss_pkg::CFG_W'($urandom_range(1, 40)));
            3: write_threshold(fss_pkg::CFG_W'($urandom()));
            default: write_threshold(fss_pkg::MIN_DIST_RESET);
         endcase
         phase_start = points_sent;
         // Some frames overrun the store; the extra points must be ignored.
         if (phase == 1) begin
            send_frame(70);
         end else if (phase % 3 == 0) begin
            send_frame($urandom_range(60, 72));
         end
         while (points_sent - phase_start < PHASE_POINTS && points_sent < TARGET_POINTS) begin
            if ($urandom_range(0, 19) == 0) begin
               size = $urandom_range(13, 40);
            end else begin
               size = $urandom_range(1, 12);
            end
            send_frame(size);
         end
      end

      settle();
      if (chooser.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

endmodule
